>>> rtl/bcp_pkg.sv
// shared types and constants of the barometric compensation core
// no dependencies; imported by every module of the block

package bcp_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMP_COEFFS   = 2'd0,
    CFG_PRESS_LOW     = 2'd1,
    CFG_PRESS_HIGH    = 2'd2,
    CFG_PRESS_NINE    = 2'd3
  } cfg_idx_t;

  // compensation constants
  localparam int FINE_OFFSET = 128000;
  localparam int PDIFF_BASE  = 1048576;
  localparam int PRESS_SCALE = 3125;
  localparam int TEMP_MUL    = 5;
  localparam int TEMP_ROUND  = 128;

  // divider geometry
  localparam int DIV_W = 64;
  localparam int DEN_W = 31;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_invalid;
  } out_item_t;

  // fields that ride along with an item through the divider
  typedef struct packed {
    logic signed [31:0] temp;
    logic               invalid;
    logic               qneg;
  } div_side_t;

endpackage

>>> rtl/bcp_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on bcp_pkg for widths and the sideband struct

module bcp_div
  import bcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DIV_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  div_side_t        in_side,
  output logic             out_valid,
  output logic [DIV_W-1:0] out_quo,
  output div_side_t        out_side
);

  logic             v_r    [DIV_W];
  logic [DIV_W-1:0] n_r    [DIV_W];
  logic [DEN_W:0]   rem_r  [DIV_W];
  logic [DEN_W-1:0] den_r  [DIV_W];
  div_side_t        side_r [DIV_W];

  logic             v_src    [DIV_W];
  logic [DIV_W-1:0] n_src    [DIV_W];
  logic [DEN_W:0]   rem_src  [DIV_W];
  logic [DEN_W-1:0] den_src  [DIV_W];
  div_side_t        side_src [DIV_W];
  logic [DEN_W:0]   trial    [DIV_W];
  logic             fits     [DIV_W];

  // stage inputs and trial subtract
  always_comb begin
    for (int k = 0; k < DIV_W; k++) begin
      if (k == 0) begin
        v_src[k]    = in_valid;
        n_src[k]    = in_num;
        rem_src[k]  = '0;
        den_src[k]  = in_den;
        side_src[k] = in_side;
      end else begin
        v_src[k]    = v_r[k-1];
        n_src[k]    = n_r[k-1];
        rem_src[k]  = rem_r[k-1];
        den_src[k]  = den_r[k-1];
        side_src[k] = side_r[k-1];
      end
      trial[k] = {rem_src[k][DEN_W-1:0], n_src[k][DIV_W-1]};
      fits[k]  = trial[k] >= {1'b0, den_src[k]};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_W; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < DIV_W; k++) v_r[k] <= v_src[k];
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_W; k++) begin
        n_r[k]    <= {n_src[k][DIV_W-2:0], fits[k]};
        rem_r[k]  <= fits[k] ? trial[k] - {1'b0, den_src[k]} : trial[k];
        den_r[k]  <= den_src[k];
        side_r[k] <= side_src[k];
      end
    end
  end

  assign out_valid = v_r[DIV_W-1];
  assign out_quo   = n_r[DIV_W-1];
  assign out_side  = side_r[DIV_W-1];

endmodule

>>> rtl/baro_temp_press_compensation_core.sv
// barometric temperature and pressure compensation, fully pipelined
// path: front stages, bit-per-stage divider, back stages, output register
// throughput: one item per cycle unless the result is stalled
// a stalled result freezes the whole pipeline, nothing is lost or repeated
// reset (rst_n low, synchronous) clears all valid bits and the coefficients
// depends on bcp_pkg and bcp_div

module baro_temp_press_compensation_core
  import bcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // calibration registers
  logic [47:0] tc_r;
  logic [63:0] pl_r;
  logic [63:0] ph_r;
  logic [15:0] p9_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= '0;
      pl_r <= '0;
      ph_r <= '0;
      p9_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP_COEFFS: tc_r <= cfg_data[47:0];
        CFG_PRESS_LOW:   pl_r <= cfg_data;
        CFG_PRESS_HIGH:  ph_r <= cfg_data;
        CFG_PRESS_NINE:  p9_r <= cfg_data[15:0];
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p8, p9;

  assign t1 = tc_r[15:0];
  assign t2 = $signed(tc_r[31:16]);
  assign t3 = $signed(tc_r[47:32]);
  assign p1 = pl_r[15:0];
  assign p2 = $signed(pl_r[31:16]);
  assign p3 = $signed(pl_r[47:32]);
  assign p4 = $signed(pl_r[63:48]);
  assign p5 = $signed(ph_r[15:0]);
  assign p6 = $signed(ph_r[31:16]);
  assign p8 = $signed(ph_r[63:48]);
  assign p9 = $signed(p9_r);

  // whole pipeline advances unless the result register is stalled
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage valid bits
  logic s_v_r [11];
  logic p_v_r [6];
  logic div_v;

  // s1: temperature differences
  logic signed [17:0] s1_d1_r;
  logic signed [16:0] s1_d2_r;
  logic [19:0]        s1_adcp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_d1_r   <= $signed({1'b0, in_data.raw_temperature[19:3]})
                 - $signed({1'b0, t1, 1'b0});
      s1_d2_r   <= $signed({1'b0, in_data.raw_temperature[19:4]}) - $signed({1'b0, t1});
      s1_adcp_r <= in_data.raw_pressure;
    end
  end

  // s2: first products
  logic signed [33:0] s2_m1_r;
  logic signed [33:0] s2_sq_r;
  logic [19:0]        s2_adcp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_m1_r   <= s1_d1_r * t2;
      s2_sq_r   <= s1_d2_r * s1_d2_r;
      s2_adcp_r <= s1_adcp_r;
    end
  end

  // s3: linear term and square times t3
  logic signed [22:0] s3_ta_r;
  logic signed [36:0] s3_tbm_r;
  logic [19:0]        s3_adcp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_ta_r   <= $signed(s2_m1_r[33:11]);
      s3_tbm_r  <= $signed({1'b0, s2_sq_r[31:12]}) * t3;
      s3_adcp_r <= s2_adcp_r;
    end
  end

  // s4: fine temperature
  logic signed [23:0] s4_fine_r;
  logic [19:0]        s4_adcp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_fine_r <= s3_ta_r + $signed(s3_tbm_r[36:14]);
      s4_adcp_r <= s3_adcp_r;
    end
  end

  // s5: temperature result and pressure offset
  logic signed [26:0] t5_nxt;
  logic signed [31:0] s5_temp_r;
  logic signed [24:0] s5_v1_r;
  logic [19:0]        s5_adcp_r;
  assign t5_nxt = s4_fine_r * $signed(27'(TEMP_MUL)) + $signed(27'(TEMP_ROUND));
  always_ff @(posedge clk) begin
    if (en) begin
      s5_temp_r <= {{13{t5_nxt[26]}}, t5_nxt[26:8]};
      s5_v1_r   <= s4_fine_r - $signed(25'(FINE_OFFSET));
      s5_adcp_r <= s4_adcp_r;
    end
  end

  // s6: square and linear products of the offset
  logic signed [49:0] s6_vsq_r;
  logic signed [40:0] s6_vp5_r;
  logic signed [40:0] s6_vp2_r;
  logic signed [31:0] s6_temp_r;
  logic [19:0]        s6_adcp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_vsq_r  <= s5_v1_r * s5_v1_r;
      s6_vp5_r  <= s5_v1_r * p5;
      s6_vp2_r  <= s5_v1_r * p2;
      s6_temp_r <= s5_temp_r;
      s6_adcp_r <= s5_adcp_r;
    end
  end

  // s7: square times p6 and p3
  logic signed [65:0] a6_full;
  logic signed [65:0] a3_full;
  logic [63:0]        s7_a6_r;
  logic [63:0]        s7_a3_r;
  logic signed [40:0] s7_vp5_r;
  logic signed [40:0] s7_vp2_r;
  logic signed [31:0] s7_temp_r;
  logic [19:0]        s7_adcp_r;
  assign a6_full = s6_vsq_r * p6;
  assign a3_full = s6_vsq_r * p3;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_a6_r   <= a6_full[63:0];
      s7_a3_r   <= a3_full[63:0];
      s7_vp5_r  <= s6_vp5_r;
      s7_vp2_r  <= s6_vp2_r;
      s7_temp_r <= s6_temp_r;
      s7_adcp_r <= s6_adcp_r;
    end
  end

  // s8: numerator offset and divisor partial sum
  logic [63:0]        s8_v2_r;
  logic [63:0]        s8_v1b_r;
  logic signed [31:0] s8_temp_r;
  logic [19:0]        s8_adcp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s8_v2_r   <= s7_a6_r + {{6{s7_vp5_r[40]}}, s7_vp5_r, 17'b0}
                 + {{13{p4[15]}}, p4, 35'b0};
      s8_v1b_r  <= {{8{s7_a3_r[63]}}, s7_a3_r[63:8]}
                 + {{11{s7_vp2_r[40]}}, s7_vp2_r, 12'b0};
      s8_temp_r <= s7_temp_r;
      s8_adcp_r <= s7_adcp_r;
    end
  end

  // s9: divisor and raw numerator
  logic [63:0]        m_nxt;
  logic signed [72:0] mp_nxt;
  logic [20:0]        pdiff_nxt;
  logic signed [30:0] s9_dv_r;
  logic [63:0]        s9_pnum_r;
  logic signed [31:0] s9_temp_r;
  assign m_nxt     = 64'h0000_8000_0000_0000 + s8_v1b_r;
  assign mp_nxt    = $signed(m_nxt[55:0]) * $signed({1'b0, p1});
  assign pdiff_nxt = 21'(PDIFF_BASE) - {1'b0, s8_adcp_r};
  always_ff @(posedge clk) begin
    if (en) begin
      s9_dv_r   <= $signed(mp_nxt[63:33]);
      s9_pnum_r <= {12'b0, pdiff_nxt, 31'b0} - s8_v2_r;
      s9_temp_r <= s8_temp_r;
    end
  end

  // s10: scaled numerator
  logic [63:0]        s10_num_r;
  logic signed [30:0] s10_dv_r;
  logic signed [31:0] s10_temp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s10_num_r  <= s9_pnum_r * 64'(PRESS_SCALE);
      s10_dv_r   <= s9_dv_r;
      s10_temp_r <= s9_temp_r;
    end
  end

  // s11: magnitudes and quotient sign
  logic [63:0] s11_an_r;
  logic [30:0] s11_ad_r;
  div_side_t   s11_side_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s11_an_r           <= s10_num_r[63] ? 64'(-s10_num_r) : s10_num_r;
      s11_ad_r           <= s10_dv_r[30] ? 31'(-s10_dv_r) : s10_dv_r;
      s11_side_r.temp    <= s10_temp_r;
      s11_side_r.invalid <= s10_dv_r == '0;
      s11_side_r.qneg    <= s10_num_r[63] ^ s10_dv_r[30];
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 11; k++) s_v_r[k] <= 1'b0;
    end else if (en) begin
      s_v_r[0] <= in_valid;
      for (int k = 1; k < 11; k++) s_v_r[k] <= s_v_r[k-1];
    end
  end

  // long division
  logic [63:0] div_quo;
  div_side_t   div_side;

  bcp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_v_r[10]),
    .in_num    (s11_an_r),
    .in_den    (s11_ad_r),
    .in_side   (s11_side_r),
    .out_valid (div_v),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // p1: signed quotient
  logic [63:0] p1_q_r;
  div_side_t   p1_side_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p1_q_r    <= div_side.qneg ? 64'(-div_quo) : div_quo;
      p1_side_r <= div_side;
    end
  end

  // p2: partial products of q*p8 and x*p9, x = q >>> 13
  logic [63:0]        x_nxt;
  logic signed [48:0] bh_full, yh_full;
  logic signed [48:0] p2_bl_r, p2_yl_r;
  logic [31:0]        p2_bh_r, p2_yh_r;
  logic [63:0]        p2_q_r, p2_x_r;
  div_side_t          p2_side_r;
  assign x_nxt   = {{13{p1_q_r[63]}}, p1_q_r[63:13]};
  assign bh_full = $signed({1'b0, p1_q_r[63:32]}) * p8;
  assign yh_full = $signed({1'b0, x_nxt[63:32]}) * p9;
  always_ff @(posedge clk) begin
    if (en) begin
      p2_bl_r   <= $signed({1'b0, p1_q_r[31:0]}) * p8;
      p2_yl_r   <= $signed({1'b0, x_nxt[31:0]}) * p9;
      p2_bh_r   <= bh_full[31:0];
      p2_yh_r   <= yh_full[31:0];
      p2_q_r    <= p1_q_r;
      p2_x_r    <= x_nxt;
      p2_side_r <= p1_side_r;
    end
  end

  // p3: assemble 64-bit wrapped products
  logic [63:0] p3_b_r, p3_y_r, p3_q_r, p3_x_r;
  div_side_t   p3_side_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p3_b_r    <= {{15{p2_bl_r[48]}}, p2_bl_r} + {p2_bh_r, 32'b0};
      p3_y_r    <= {{15{p2_yl_r[48]}}, p2_yl_r} + {p2_yh_r, 32'b0};
      p3_q_r    <= p2_q_r;
      p3_x_r    <= p2_x_r;
      p3_side_r <= p2_side_r;
    end
  end

  // p4: partial products of y*x
  logic [63:0] c1_full, c2_full;
  logic [63:0] p4_ll_r;
  logic [31:0] p4_c1_r, p4_c2_r;
  logic [63:0] p4_q_r, p4_b_r;
  div_side_t   p4_side_r;
  assign c1_full = p3_y_r[31:0] * p3_x_r[63:32];
  assign c2_full = p3_y_r[63:32] * p3_x_r[31:0];
  always_ff @(posedge clk) begin
    if (en) begin
      p4_ll_r   <= p3_y_r[31:0] * p3_x_r[31:0];
      p4_c1_r   <= c1_full[31:0];
      p4_c2_r   <= c2_full[31:0];
      p4_q_r    <= p3_q_r;
      p4_b_r    <= p3_b_r;
      p4_side_r <= p3_side_r;
    end
  end

  // p5: second-order term and partial correction sum
  logic [31:0] cs_nxt;
  logic [63:0] p5_z_r, p5_qb_r;
  div_side_t   p5_side_r;
  assign cs_nxt = p4_c1_r + p4_c2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p5_z_r    <= p4_ll_r + {cs_nxt, 32'b0};
      p5_qb_r   <= p4_q_r + {{19{p4_b_r[63]}}, p4_b_r[63:19]};
      p5_side_r <= p4_side_r;
    end
  end

  // p6: corrected pressure before the final shift
  logic [63:0] p6_s_r;
  div_side_t   p6_side_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p6_s_r    <= p5_qb_r + {{25{p5_z_r[63]}}, p5_z_r[63:25]};
      p6_side_r <= p5_side_r;
    end
  end

  // valid bits of the back stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) p_v_r[k] <= 1'b0;
    end else if (en) begin
      p_v_r[0] <= div_v;
      for (int k = 1; k < 6; k++) p_v_r[k] <= p_v_r[k-1];
    end
  end

  // output register with clamp to 32 bits; an invalid item gives zero pressure
  logic [31:0] press_nxt;
  out_item_t   out_data_r;
  always_comb begin
    priority if (p6_side_r.invalid || p6_s_r[63]) begin
      press_nxt = '0;
    end else if (p6_s_r[62:40] != '0) begin
      press_nxt = '1;
    end else begin
      press_nxt = p6_s_r[39:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p_v_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.temperature_centi <= p6_side_r.temp;
      out_data_r.pressure_q24_8    <= press_nxt;
      out_data_r.pressure_invalid  <= p6_side_r.invalid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/bcp_chk.sv
// port-level checks of the compensation core, attached by bind
// depends on bcp_pkg and the core's port list

module bcp_chk
  import bcp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [63:0] cfg_data
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input side is stalled exactly when the result is stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // zero divisor forces pressure to zero
  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pressure_invalid |-> out_data.pressure_q24_8 == '0)
    else $error("invalid pressure item carries nonzero pressure");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind baro_temp_press_compensation_core bcp_chk u_bcp_chk (.*);

>>> tb/baro_temp_press_compensation_core_test.sv
// self-checking testbench for the barometric compensation core, directed and random items
// depends on bcp_pkg and the core; compares each result with a predictor or a fixed value
`timescale 1ns / 100ps

module baro_temp_press_compensation_core_test;
  import bcp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  baro_temp_press_compensation_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // coefficient copy used by the predictor
  logic [47:0] coef_temp;
  logic [63:0] coef_plow, coef_phigh;
  logic [15:0] coef_p9;

  out_item_t   pending_results[$];
  int          fail_count = 0;
  int          result_count = 0;
  int          invalid_count = 0;
  int          saturate_count = 0;
  bit          hold_off = 1'b0;

  // directed table: raw temperature, raw pressure
  typedef struct {
    logic [19:0] rt;
    logic [19:0] rp;
  } dir_row_t;

  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // integer compensation of one reading pair
  function automatic out_item_t compensate(input in_item_t it);
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p8, p9;
    logic signed [63:0] adc_t, adc_p, d1, d2, fine, temp;
    logic signed [63:0] v1, v2, p, a, b, num;
    logic [63:0] an, ad, q;
    out_item_t r;
    t1 = {48'd0, coef_temp[15:0]};
    t2 = sx16(coef_temp[31:16]);
    t3 = sx16(coef_temp[47:32]);
    p1 = {48'd0, coef_plow[15:0]};
    p2 = sx16(coef_plow[31:16]);
    p3 = sx16(coef_plow[47:32]);
    p4 = sx16(coef_plow[63:48]);
    p5 = sx16(coef_phigh[15:0]);
    p6 = sx16(coef_phigh[31:16]);
    p8 = sx16(coef_phigh[63:48]);
    p9 = sx16(coef_p9);
    adc_t = {44'd0, it.raw_temperature};
    adc_p = {44'd0, it.raw_pressure};
    // temperature path
    d1 = (adc_t >>> 3) - (t1 <<< 1);
    d2 = (adc_t >>> 4) - t1;
    fine = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
    temp = (fine * 64'sd5 + 64'sd128) >>> 8;
    r = '0;
    r.temperature_centi = temp[31:0];
    // pressure path, 64-bit wrapping
    v1 = fine - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      r.pressure_invalid = 1'b1;
    end else begin
      p = 64'sd1048576 - adc_p;
      num = ((p <<< 31) - v2) * 64'sd3125;
      an = num[63] ? -num : num;
      ad = v1[63] ? -v1 : v1;
      q = an / ad;
      p = (num[63] != v1[63]) ? -q : q;
      a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      b = (p8 * p) >>> 19;
      p = (p + a + b) >>> 8;
      if (p[63]) r.pressure_q24_8 = '0;
      else if (p[63:32] != 0) r.pressure_q24_8 = 32'hFFFF_FFFF;
      else r.pressure_q24_8 = p[31:0];
    end
    return r;
  endfunction

  // random gap, mostly short, a few long
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TEMP_COEFFS: coef_temp = val[47:0];
      CFG_PRESS_LOW:   coef_plow = val;
      CFG_PRESS_HIGH:  coef_phigh = val;
      CFG_PRESS_NINE:  coef_p9 = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // send one item; queue its prediction, or a fixed expectation if given
  // valid stays high after acceptance when the next item follows back to back
  task automatic send_item(input in_item_t it, input bit fixed, input out_item_t fixed_res);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    pending_results.push_back(fixed ? fixed_res : compensate(it));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // typical calibration set with random perturbation
  task automatic load_typical();
    logic [15:0] t1, p1;
    t1 = 16'd27504 + 16'($urandom_range(0, 4000)) - 16'd2000;
    p1 = 16'd36477 + 16'($urandom_range(0, 4000)) - 16'd2000;
    write_reg(CFG_TEMP_COEFFS, {16'd0, 16'hFC18 + 16'($urandom_range(0, 16)),
                                16'd26435 + 16'($urandom_range(0, 500)), t1});
    write_reg(CFG_PRESS_LOW, {16'd2855 + 16'($urandom_range(0, 200)),
                              16'd3024 + 16'($urandom_range(0, 200)),
                              16'hD4BD + 16'($urandom_range(0, 200)), p1});
    write_reg(CFG_PRESS_HIGH, {16'hFFF9, 16'd15500, 16'hFFF9, 16'd140});
    write_reg(CFG_PRESS_NINE, 64'd6000 + 64'($urandom_range(0, 200)));
  endtask

  task automatic load_random();
    write_reg(CFG_TEMP_COEFFS, {$urandom, $urandom});
    write_reg(CFG_PRESS_LOW, {$urandom, $urandom});
    write_reg(CFG_PRESS_HIGH, {$urandom, $urandom});
    write_reg(CFG_PRESS_NINE, {$urandom, $urandom});
  endtask

  task automatic random_items(input int n, input bit realistic);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      if (realistic && $urandom_range(0, 9) < 8) begin
        it.raw_temperature = 20'($urandom_range(400000, 620000));
        it.raw_pressure = 20'($urandom_range(200000, 480000));
      end else begin
        it.raw_temperature = 20'($urandom);
        it.raw_pressure = 20'($urandom);
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int g;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g != 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: %h", out_data);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        result_count++;
        if (out_data.pressure_invalid) invalid_count++;
        if (out_data.pressure_q24_8 == 32'hFFFF_FFFF) saturate_count++;
        if (out_data.temperature_centi !== exp_res.temperature_centi) begin
          $error("temperature_centi expected %0d actual %0d",
                 exp_res.temperature_centi, out_data.temperature_centi);
          fail_count++;
        end
        if (out_data.pressure_q24_8 !== exp_res.pressure_q24_8) begin
          $error("pressure_q24_8 expected %h actual %h",
                 exp_res.pressure_q24_8, out_data.pressure_q24_8);
          fail_count++;
        end
        if (out_data.pressure_invalid !== exp_res.pressure_invalid) begin
          $error("pressure_invalid expected %b actual %b",
                 exp_res.pressure_invalid, out_data.pressure_invalid);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // main sequence
  initial begin
    dir_row_t dir_rows[$];
    out_item_t zero_res;
    in_item_t it;
    coef_temp = '0;
    coef_plow = '0;
    coef_phigh = '0;
    coef_p9 = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset all coefficients are zero: temperature 0, divisor 0
    zero_res = '0;
    zero_res.pressure_invalid = 1'b1;
    dir_rows = '{'{20'd0, 20'd0}, '{20'hFFFFF, 20'hFFFFF}, '{20'h55555, 20'hAAAAA},
                 '{20'hAAAAA, 20'h55555}};
    foreach (dir_rows[i]) begin
      it.raw_temperature = dir_rows[i].rt;
      it.raw_pressure = dir_rows[i].rp;
      send_item(it, 1'b1, zero_res);
    end
    drain();

    // typical calibration: extremes and in-range readings, predicted
    load_typical();
    dir_rows = '{'{20'd0, 20'd0}, '{20'hFFFFF, 20'hFFFFF}, '{20'd0, 20'hFFFFF},
                 '{20'hFFFFF, 20'd0}, '{20'd519888, 20'd415148},
                 '{20'd500000, 20'd300000}, '{20'd600000, 20'd200000},
                 '{20'h80000, 20'h80000}, '{20'h7FFFF, 20'h7FFFF}};
    foreach (dir_rows[i]) begin
      it.raw_temperature = dir_rows[i].rt;
      it.raw_pressure = dir_rows[i].rp;
      send_item(it, 1'b0, '0);
    end
    drain();

    // extreme coefficients: all ones, then most negative / largest fields
    write_reg(CFG_TEMP_COEFFS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PRESS_NINE, 64'hFFFF);
    random_items(6, 1'b0);
    drain();
    write_reg(CFG_TEMP_COEFFS, 64'h0000_8000_7FFF_FFFF);
    write_reg(CFG_PRESS_LOW, 64'h8000_7FFF_8000_FFFF);
    write_reg(CFG_PRESS_HIGH, 64'h7FFF_8000_7FFF_8000);
    write_reg(CFG_PRESS_NINE, 64'h8000);
    random_items(6, 1'b0);
    drain();

    // random phases: mostly realistic calibration, some random
    // each phase empties the pipeline before new coefficients go in
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) drain();
      if (ph % 3 == 2) load_random();
      else load_typical();
      if (ph == 1) hold_off = 1'b1;
      random_items(70, ph % 3 != 2);
    end
    drain();

    $display("covered %0d results, %0d with zero divisor, %0d saturated",
             result_count, invalid_count, saturate_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bcp_pkg.sv
rtl/bcp_div.sv
rtl/baro_temp_press_compensation_core.sv
rtl/bcp_chk.sv
tb/baro_temp_press_compensation_core_test.sv
